// ===== hw/rtl/ptpts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpts_pkg
// Shared types and constants for the PTP transparent clock stamping block.
// ----------------------------------------------------------------------------
package ptpts_pkg;

    // Verdict codes carried in the result item.
    typedef enum logic [2:0] {
        ACT_PASS      = 3'd0,
        ACT_DROP_LEN  = 3'd1,
        ACT_DROP_CSUM = 3'd2,
        ACT_OTHER     = 3'd3,
        ACT_INGRESS   = 3'd4,
        ACT_HW        = 3'd5,
        ACT_CORRECTED = 3'd6
    } t_action;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_CLASSIFY = 3'd0,
        REG_CSUM     = 3'd1,
        REG_USE_HW   = 3'd2,
        REG_TOFF     = 3'd3,
        REG_PPB      = 3'd4
    } t_reg_idx;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [15:0] PTP_EVENT_PORT   = 16'd319;
    localparam int          CORRECTION_SHIFT = 16;
    localparam logic [3:0]  MSG_SYNC         = 4'd0;
    localparam logic [3:0]  MSG_DELAY_REQ    = 4'd1;

    // 1e9 = 2^9 * 1953125. The odd factor is divided out with a reciprocal
    // multiply that is exact to within one, followed by a single correction.
    localparam int          NS_POW2_SHIFT = 9;
    localparam logic [20:0] DIV_ODD       = 21'd1953125;
    localparam int          RECIP_SHIFT   = 43;
    localparam logic [22:0] RECIP         =
        23'((64'd1 << RECIP_SHIFT) / 64'(DIV_ODD));

    localparam int FIFO_DEPTH_DEF = 2;

    typedef struct packed {
        logic        is_egress;
        logic        hw_ptp_flag;
        logic        rx_csum_bad;
        logic        is_udp;
        logic [15:0] ip_payload_length;
        logic [15:0] udp_length;
        logic [15:0] udp_dst_port;
        logic        l4_csum_good;
        logic [3:0]  msg_type;
        logic [63:0] timestamp_ns;
        logic [31:0] type_specific_in;
        logic [63:0] correction_in;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [31:0] type_specific_out;
        logic [63:0] correction_out;
        logic [63:0] tx_timestamp;
    } t_out_item;

    typedef struct packed {
        logic               classify;
        logic               csum;
        logic               use_hw;
        logic [31:0]        toff;
        logic signed [20:0] ppb;
    } t_cfg;

    // One classified item on its way from the front end to the back end.
    typedef struct packed {
        logic        calc;
        t_action     action;
        logic [63:0] ts;
        logic [31:0] diff;
        logic [32:0] base;
        logic [31:0] tsf;
        logic [63:0] corr;
    } t_work;

endpackage

// ===== hw/rtl/ptpts_front.sv =====
// ----------------------------------------------------------------------------
// ptpts_front
// Classifies one packet header into a verdict, or marks it for the egress
// residence time calculation.
// ----------------------------------------------------------------------------
module ptpts_front (
    input  ptpts_pkg::t_in_item i_item,
    input  ptpts_pkg::t_cfg     i_cfg,
    output ptpts_pkg::t_work    o_work
);
    import ptpts_pkg::*;

    logic filtered;
    logic csum_good;
    logic evt_msg;

    always_comb begin
        filtered  = !i_item.is_egress &&
                    ((i_cfg.classify && !i_item.hw_ptp_flag) ||
                     (i_cfg.csum && i_item.rx_csum_bad));
        csum_good = (!i_item.is_egress && i_cfg.csum) || i_item.l4_csum_good;
        evt_msg   = (i_item.msg_type == MSG_SYNC) ||
                    (i_item.msg_type == MSG_DELAY_REQ);

        o_work.calc   = 1'b0;
        o_work.action = ACT_PASS;
        o_work.ts     = i_item.timestamp_ns;
        o_work.diff   = i_item.timestamp_ns[31:0] - i_item.type_specific_in;
        o_work.base   = '0;
        o_work.tsf    = i_item.type_specific_in;
        o_work.corr   = i_item.correction_in;

        priority if (filtered || !i_item.is_udp) begin
            o_work.action = ACT_PASS;
        end else if (i_item.udp_length > i_item.ip_payload_length) begin
            o_work.action = ACT_DROP_LEN;
        end else if (i_item.udp_dst_port != PTP_EVENT_PORT) begin
            o_work.action = ACT_PASS;
        end else if (!csum_good) begin
            o_work.action = ACT_DROP_CSUM;
        end else if (!evt_msg) begin
            o_work.action = ACT_OTHER;
        end else if (!i_item.is_egress) begin
            o_work.action = ACT_INGRESS;
            o_work.tsf    = i_item.timestamp_ns[31:0];
        end else begin
            // Final verdict for egress is settled in the back end.
            o_work.calc = 1'b1;
            o_work.tsf  = '0;
        end
    end

endmodule

// ===== hw/rtl/ptpts_fifo.sv =====
// ----------------------------------------------------------------------------
// ptpts_fifo
// Short queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module ptpts_fifo #(
    parameter int DEPTH = ptpts_pkg::FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ptpts_pkg::t_work i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output ptpts_pkg::t_work o_data
);
    import ptpts_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_work          r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wp;
    logic [PW-1:0]  n_rp;
    logic [CW-1:0]  n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count exceeds its depth");

endmodule

// ===== hw/rtl/ptpts_back.sv =====
// ----------------------------------------------------------------------------
// ptpts_back
// Residence time pipeline: rate adjustment by signed multiply and
// divide-by-1e9, then transmit time or correction field update.
// ----------------------------------------------------------------------------
module ptpts_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptpts_pkg::t_cfg      i_cfg,
    input  logic                 i_empty,
    input  ptpts_pkg::t_work     i_work,
    output logic                 o_pop,
    output logic                 o_done,
    output ptpts_pkg::t_out_item o_result
);
    import ptpts_pkg::*;

    localparam int NSTG = 8;

    logic [NSTG-1:0] r_v;
    t_work           r_w [NSTG];

    logic signed [53:0] r_p1;
    logic [42:0]        r_a2, r_a3, r_a4, r_a5;
    logic               r_neg2, r_neg3, r_neg4, r_neg5, r_neg6;
    logic [54:0]        r_pl3;
    logic [33:0]        r_ph3;
    logic [22:0]        r_qe4, r_qe5;
    logic [43:0]        r_qd5;
    logic [22:0]        r_q6;
    logic [63:0]        r_res7;
    logic               r_done;
    t_out_item          r_result;

    t_work              n_w1;
    logic signed [53:0] n_p1;
    logic [53:0]        n_mag;
    logic [54:0]        n_pl;
    logic [33:0]        n_ph;
    logic [65:0]        n_sum;
    logic [43:0]        n_qd;
    logic [43:0]        n_rem;
    logic [22:0]        n_q;
    logic [63:0]        n_res;
    t_out_item          n_result;

    // The pipeline never stalls, so it drains the queue whenever it holds an item.
    assign o_pop    = !i_empty;
    assign o_done   = r_done;
    assign o_result = r_result;

    always_comb begin
        n_w1      = r_w[0];
        n_w1.base = {1'b0, r_w[0].diff} + {1'b0, i_cfg.toff};
        n_p1      = $signed({1'b0, r_w[0].diff}) * i_cfg.ppb;

        // |p| < 2^52; the low nine bits drop out with the power-of-two factor.
        n_mag = r_p1[53] ? 54'(-r_p1) : 54'(r_p1);

        n_pl  = 55'(r_a2[31:0]) * 55'(RECIP);
        n_ph  = 34'(r_a2[42:32]) * 34'(RECIP);
        n_sum = 66'(r_pl3) + {r_ph3, 32'd0};
        n_qd  = 44'(r_qe4) * 44'(DIV_ODD);

        // The estimate is the true quotient or one below it.
        n_rem = 44'(r_a5) - r_qd5;
        n_q   = r_qe5 + 23'(n_rem >= 44'(DIV_ODD));

        n_res = r_neg6 ? 64'(r_w[6].base) + 64'(r_q6)
                       : 64'(r_w[6].base) - 64'(r_q6);

        n_result.action            = r_w[7].action;
        n_result.type_specific_out = r_w[7].tsf;
        n_result.correction_out    = r_w[7].corr;
        n_result.tx_timestamp      = '0;
        if (r_w[7].calc) begin
            if (i_cfg.use_hw) begin
                n_result.action       = ACT_HW;
                n_result.tx_timestamp = r_w[7].ts - r_res7;
            end else begin
                n_result.action         = ACT_CORRECTED;
                n_result.correction_out = r_w[7].corr + (r_res7 << CORRECTION_SHIFT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[NSTG-2:0], !i_empty};
            r_done <= r_v[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_w[0] <= i_work;
        r_w[1] <= n_w1;
        for (int k = 2; k < NSTG; k++) begin
            r_w[k] <= r_w[k-1];
        end
        r_p1     <= n_p1;
        r_a2     <= n_mag[51:NS_POW2_SHIFT];
        r_neg2   <= r_p1[53];
        r_pl3    <= n_pl;
        r_ph3    <= n_ph;
        r_a3     <= r_a2;
        r_neg3   <= r_neg2;
        r_qe4    <= n_sum[65:RECIP_SHIFT];
        r_a4     <= r_a3;
        r_neg4   <= r_neg3;
        r_qd5    <= n_qd;
        r_qe5    <= r_qe4;
        r_a5     <= r_a4;
        r_neg5   <= r_neg4;
        r_q6     <= n_q;
        r_neg6   <= r_neg5;
        r_res7   <= n_res;
        r_result <= n_result;
    end

    a_egress_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && r_w[0].calc) |-> ##8
        (o_done && (o_result.action == ACT_HW || o_result.action == ACT_CORRECTED)))
        else $error("egress item did not leave with a stamping verdict");

    a_hw_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.action == ACT_HW) |-> (o_result.type_specific_out == '0))
        else $error("hardware stamp left a nonzero type specific field");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.action != ACT_HW) |-> (o_result.tx_timestamp == '0))
        else $error("transmit time set on an item without a hardware stamp");

endmodule

// ===== hw/rtl/ptp_transparent_clock_stamp.sv =====
// ----------------------------------------------------------------------------
// ptp_transparent_clock_stamp
// PTP transparent clock stamping: verdict, ingress stamp and egress
// residence time correction for parsed PTP-over-UDP headers.
// ----------------------------------------------------------------------------
// One header is accepted per clock cycle while busy is low, and its result
// strobes out on o_done in order, after the residence time arithmetic
// (signed rate multiply, reciprocal divide by 1e9 with one correction step,
// then the final 64-bit update); every item takes the same path so order is
// kept. The result cannot be held off by the receiver and none is needed:
// busy stays low in steady operation. Configuration is to be written over
// the APB port only while no item is in flight; the block does not enforce
// this. pready is always high.
module ptp_transparent_clock_stamp #(
    parameter int FIFO_DEPTH = ptpts_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ptpts_pkg::t_in_item             i_item,
    output logic                            o_done,
    output ptpts_pkg::t_out_item            o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptpts_pkg::APB_AW-1:0]    paddr,
    input  logic [ptpts_pkg::APB_DW-1:0]    pwdata,
    output logic [ptpts_pkg::APB_DW-1:0]    prdata,
    output logic                            pready
);
    import ptpts_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;
    logic     accept;
    t_work    front_work;
    t_work    q_work;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign busy    = q_full;
    assign accept  = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.classify <= 1'b0;
            r_cfg.csum     <= 1'b0;
            r_cfg.use_hw   <= 1'b1;
            r_cfg.toff     <= '0;
            r_cfg.ppb      <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CLASSIFY: r_cfg.classify <= pwdata[0];
                REG_CSUM:     r_cfg.csum     <= pwdata[0];
                REG_USE_HW:   r_cfg.use_hw   <= pwdata[0];
                REG_TOFF:     r_cfg.toff     <= pwdata;
                REG_PPB:      r_cfg.ppb      <= $signed(pwdata[20:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CLASSIFY: prdata = {31'd0, r_cfg.classify};
            REG_CSUM:     prdata = {31'd0, r_cfg.csum};
            REG_USE_HW:   prdata = {31'd0, r_cfg.use_hw};
            REG_TOFF:     prdata = r_cfg.toff;
            REG_PPB:      prdata = {{11{r_cfg.ppb[20]}}, r_cfg.ppb};
            default:      prdata = '0;
        endcase
    end

    ptpts_front u_front (
        .i_item (i_item),
        .i_cfg  (r_cfg),
        .o_work (front_work)
    );

    ptpts_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_work)
    );

    ptpts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (q_empty),
        .i_work   (q_work),
        .o_pop    (q_pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue filled although the pipeline drains it every cycle");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PTP transparent clock stamping block. A short
// table of directed headers, then random phases under changing register
// settings. Each accepted header is scored by its table row or by a local
// verdict calculator, and the results are compared in order as they strobe out.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptpts_pkg::*;

    localparam int PIPE_LAT     = 9;
    localparam int DIR_ROWS     = 24;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 225;

    // Register settings used by the directed table.
    localparam t_cfg CFG_RESET    = '{1'b0, 1'b0, 1'b1, 32'd0, 21'sd0};
    localparam t_cfg CFG_OFFLOAD  = '{1'b1, 1'b1, 1'b1, 32'd0, 21'sd0};
    localparam t_cfg CFG_CORR_MAX = '{1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 21'sd1000000};
    localparam t_cfg CFG_CORR_MIN = '{1'b0, 1'b0, 1'b0, 32'd0, -21'sd1000000};
    localparam t_cfg CFG_HW_EDGE  = '{1'b1, 1'b0, 1'b1, 32'h8000_0001, 21'h100000};
    localparam t_cfg CFG_ALL_ON   = '{1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 21'h0FFFFF};

    typedef struct {
        t_cfg      setting;
        t_in_item  hdr;
        bit        typed;
        t_out_item verdict;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    t_in_item            i_item  = '0;
    logic                o_done;
    t_out_item           o_result;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    t_cfg        cur_cfg;
    t_out_item   pending_verdicts[$];
    int unsigned burst_left = 0;
    int          err_cnt = 0;

    // Field order: is_egress, hw_ptp_flag, rx_csum_bad, is_udp, ip_payload_length,
    // udp_length, udp_dst_port, l4_csum_good, msg_type, timestamp_ns,
    // type_specific_in, correction_in.
    t_dir_row dir_tab [DIR_ROWS] = '{
        // Not UDP on egress: untouched.
        '{CFG_RESET, '{1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'h0000, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
          1'b1, '{ACT_PASS, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0}},
        // UDP length larger than the IPv6 payload.
        '{CFG_RESET, '{1'b0, 1'b0, 1'b0, 1'b1, 16'h0000, 16'hFFFF, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 64'd0},
          1'b1, '{ACT_DROP_LEN, 32'hDEAD_BEEF, 64'd0, 64'd0}},
        // Lengths within bounds, not the event port.
        '{CFG_RESET, '{1'b0, 1'b0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, PTP_EVENT_PORT + 16'd1,
            1'b1, MSG_SYNC, 64'd7, 32'd0, 64'd5},
          1'b1, '{ACT_PASS, 32'd0, 64'd5, 64'd0}},
        '{CFG_RESET, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd80, 16'd8, 16'hFFFF, 1'b1,
            MSG_DELAY_REQ, 64'd9, 32'd3, 64'd2},
          1'b1, '{ACT_PASS, 32'd3, 64'd2, 64'd0}},
        // Checksum not known good.
        '{CFG_RESET, '{1'b0, 1'b1, 1'b0, 1'b1, 16'd100, 16'd44, PTP_EVENT_PORT, 1'b0,
            MSG_SYNC, 64'h1000, 32'h1234_5678, 64'h55},
          1'b1, '{ACT_DROP_CSUM, 32'h1234_5678, 64'h55, 64'd0}},
        // General and event messages that are neither Sync nor Delay_Req.
        '{CFG_RESET, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd44, 16'd44, PTP_EVENT_PORT, 1'b1,
            4'hF, 64'h2000, 32'h0000_0001, 64'h77},
          1'b1, '{ACT_OTHER, 32'h0000_0001, 64'h77, 64'd0}},
        '{CFG_RESET, '{1'b0, 1'b0, 1'b0, 1'b1, 16'd44, 16'd44, PTP_EVENT_PORT, 1'b1,
            4'h2, 64'h3000, 32'hCAFE_0000, 64'h0},
          1'b1, '{ACT_OTHER, 32'hCAFE_0000, 64'h0, 64'd0}},
        // Ingress stamping.
        '{CFG_RESET, '{1'b0, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'hFEDC_BA98_7654_3210, 32'h1111_1111, 64'hAAAA_AAAA_AAAA_AAAA},
          1'b1, '{ACT_INGRESS, 32'h7654_3210, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0}},
        '{CFG_RESET, '{1'b0, 1'b1, 1'b1, 1'b1, 16'd52, 16'd0, PTP_EVENT_PORT, 1'b1,
            MSG_DELAY_REQ, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 64'd0},
          1'b1, '{ACT_INGRESS, 32'hFFFF_FFFF, 64'd0, 64'd0}},
        // Egress with zero residence: hardware gets the clock unchanged.
        '{CFG_RESET, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 64'h1234},
          1'b1, '{ACT_HW, 32'd0, 64'h1234, 64'hFFFF_FFFF_FFFF_FFFF}},
        // Residence difference wrapping to its largest value, then a small one.
        '{CFG_RESET, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_DELAY_REQ, 64'h0000_0005_0000_0000, 32'h0000_0001, 64'd0},
          1'b0, '0},
        '{CFG_RESET, '{1'b1, 1'b1, 1'b1, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'h0000_0001_0000_0100, 32'd0, 64'd0},
          1'b0, '0},
        // Offload filters on ingress only.
        '{CFG_OFFLOAD, '{1'b0, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'h4444, 32'h9, 64'h8},
          1'b1, '{ACT_PASS, 32'h9, 64'h8, 64'd0}},
        '{CFG_OFFLOAD, '{1'b0, 1'b1, 1'b1, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'h4444, 32'h9, 64'h8},
          1'b1, '{ACT_PASS, 32'h9, 64'h8, 64'd0}},
        '{CFG_OFFLOAD, '{1'b0, 1'b1, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b0,
            MSG_SYNC, 64'h0000_0000_8765_4321, 32'h9, 64'h8},
          1'b0, '0},
        '{CFG_OFFLOAD, '{1'b1, 1'b0, 1'b1, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b0,
            MSG_SYNC, 64'h4444, 32'h9, 64'h8},
          1'b1, '{ACT_DROP_CSUM, 32'h9, 64'h8, 64'd0}},
        '{CFG_OFFLOAD, '{1'b0, 1'b1, 1'b0, 1'b0, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'h4444, 32'h9, 64'h8},
          1'b0, '0},
        // Correction field updates at the rate extremes.
        '{CFG_CORR_MAX, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
          1'b0, '0},
        '{CFG_CORR_MAX, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_DELAY_REQ, 64'h0000_0000_0000_1000, 32'h0000_1000, 64'h10},
          1'b0, '0},
        '{CFG_CORR_MIN, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'h0000_0000_0000_0000, 32'h0000_0001, 64'h0},
          1'b0, '0},
        '{CFG_CORR_MIN, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'h0000_0000_0000_03E7, 32'h0000_0000, 64'h0},
          1'b0, '0},
        // Full 21-bit rate field, both ends.
        '{CFG_HW_EDGE, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'h0000_0001_0000_0000, 32'h0000_0001, 64'h0},
          1'b0, '0},
        '{CFG_HW_EDGE, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_DELAY_REQ, 64'h0000_0000_0000_03E8, 32'h0000_0000, 64'h0},
          1'b0, '0},
        '{CFG_ALL_ON, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd52, 16'd52, PTP_EVENT_PORT, 1'b1,
            MSG_SYNC, 64'h0000_0000_0000_0000, 32'h0000_0001, 64'h0},
          1'b0, '0}
    };

    ptp_transparent_clock_stamp u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Verdict and rewritten fields for one header under the current settings.
    function automatic t_out_item stamp_verdict(t_in_item hdr);
        t_out_item   v;
        logic        csum_ok;
        logic [31:0] diff;
        longint      rate_adj;
        logic [63:0] resid;
        v.action            = ACT_PASS;
        v.type_specific_out = hdr.type_specific_in;
        v.correction_out    = hdr.correction_in;
        v.tx_timestamp      = '0;
        csum_ok             = 1'b0;
        if (!hdr.is_egress) begin
            if (cur_cfg.classify && !hdr.hw_ptp_flag)
                return v;
            if (cur_cfg.csum) begin
                if (hdr.rx_csum_bad)
                    return v;
                csum_ok = 1'b1;
            end
        end
        if (!hdr.is_udp)
            return v;
        if (hdr.udp_length > hdr.ip_payload_length) begin
            v.action = ACT_DROP_LEN;
            return v;
        end
        if (hdr.udp_dst_port != PTP_EVENT_PORT)
            return v;
        if (hdr.l4_csum_good)
            csum_ok = 1'b1;
        if (!csum_ok) begin
            v.action = ACT_DROP_CSUM;
            return v;
        end
        if (hdr.msg_type != MSG_SYNC && hdr.msg_type != MSG_DELAY_REQ) begin
            v.action = ACT_OTHER;
            return v;
        end
        if (!hdr.is_egress) begin
            v.type_specific_out = hdr.timestamp_ns[31:0];
            v.action            = ACT_INGRESS;
            return v;
        end
        diff     = hdr.timestamp_ns[31:0] - hdr.type_specific_in;
        // Signed division truncates toward zero, as the rate trim requires.
        rate_adj = (longint'({32'd0, diff}) * longint'(cur_cfg.ppb)) / 64'sd1000000000;
        resid    = {32'd0, diff} + {32'd0, cur_cfg.toff} - unsigned'(rate_adj);
        v.type_specific_out = '0;
        if (cur_cfg.use_hw) begin
            v.tx_timestamp = hdr.timestamp_ns - resid;
            v.action       = ACT_HW;
        end else begin
            v.correction_out = hdr.correction_in + (resid << CORRECTION_SHIFT);
            v.action         = ACT_CORRECTED;
        end
        return v;
    endfunction

    // Leaves psel high so back-to-back writes never drop and raise it in one step.
    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
    endtask

    task automatic apply_cfg(t_cfg setting);
        write_reg(REG_CLASSIFY, {31'd0, setting.classify});
        write_reg(REG_CSUM,     {31'd0, setting.csum});
        write_reg(REG_USE_HW,   {31'd0, setting.use_hw});
        write_reg(REG_TOFF,     setting.toff);
        write_reg(REG_PPB,      32'(setting.ppb));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_cfg = setting;
    endtask

    // Stop sending and wait until every outstanding item has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    task automatic drive_item(t_in_item hdr, t_out_item verdict);
        int unsigned gap;
        start  <= 1'b1;
        i_item <= hdr;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_verdicts.push_back(verdict);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            // Mostly short bursts, now and then a long unbroken stretch.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $error("result with no item outstanding, action %0d", o_result.action);
                err_cnt++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_result.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, o_result.action);
                    err_cnt++;
                end
                if (o_result.type_specific_out !== want.type_specific_out) begin
                    $error("type_specific_out: expected %h, got %h",
                           want.type_specific_out, o_result.type_specific_out);
                    err_cnt++;
                end
                if (o_result.correction_out !== want.correction_out) begin
                    $error("correction_out: expected %h, got %h",
                           want.correction_out, o_result.correction_out);
                    err_cnt++;
                end
                if (o_result.tx_timestamp !== want.tx_timestamp) begin
                    $error("tx_timestamp: expected %h, got %h",
                           want.tx_timestamp, o_result.tx_timestamp);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        t_cfg     setting;
        t_in_item hdr;
        int       pick;

        cur_cfg = CFG_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].setting != cur_cfg) begin
                drain();
                apply_cfg(dir_tab[r].setting);
            end
            drive_item(dir_tab[r].hdr, dir_tab[r].typed ? dir_tab[r].verdict
                                                        : stamp_verdict(dir_tab[r].hdr));
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            setting.classify = 1'($urandom_range(0, 1));
            setting.csum     = 1'($urandom_range(0, 1));
            setting.use_hw   = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       setting.toff = 32'd0;
                1:       setting.toff = 32'hFFFF_FFFF;
                2:       setting.toff = $urandom_range(0, 5000);
                default: setting.toff = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       setting.ppb = 21'sd0;
                1:       setting.ppb = 21'sd1000000;
                2:       setting.ppb = -21'sd1000000;
                3:       setting.ppb = ($urandom_range(0, 1) != 0) ? 21'h100000 : 21'h0FFFFF;
                default: setting.ppb = 21'(int'($urandom_range(0, 2000000)) - 1000000);
            endcase
            drain();
            apply_cfg(setting);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                hdr.is_egress         = 1'($urandom_range(0, 1));
                hdr.hw_ptp_flag       = 1'($urandom_range(0, 1));
                hdr.rx_csum_bad       = 1'($urandom_range(0, 1));
                hdr.is_udp            = 1'($urandom_range(0, 1));
                hdr.ip_payload_length = 16'($urandom);
                hdr.udp_length        = 16'($urandom);
                hdr.udp_dst_port      = ($urandom_range(0, 1) != 0) ? PTP_EVENT_PORT
                                                                    : 16'($urandom);
                hdr.l4_csum_good      = 1'($urandom_range(0, 1));
                hdr.msg_type          = 4'($urandom);
                hdr.timestamp_ns      = {$urandom, $urandom};
                hdr.type_specific_in  = $urandom;
                hdr.correction_in     = {$urandom, $urandom};
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    // Well-formed event message with random content.
                    hdr.is_udp       = 1'b1;
                    hdr.udp_dst_port = PTP_EVENT_PORT;
                    hdr.udp_length   = 16'($urandom_range(0, hdr.ip_payload_length));
                    hdr.l4_csum_good = 1'b1;
                    hdr.msg_type     = ($urandom_range(0, 1) != 0) ? MSG_SYNC : MSG_DELAY_REQ;
                    if ($urandom_range(0, 9) != 0) begin
                        hdr.hw_ptp_flag = 1'b1;
                        hdr.rx_csum_bad = 1'b0;
                    end
                    // Realistic residence times most of the time.
                    if ($urandom_range(0, 2) != 0)
                        hdr.type_specific_in = hdr.timestamp_ns[31:0]
                                               - 32'($urandom_range(0, 200000));
                    // One broken step in an otherwise good header.
                    if (pick >= 70) begin
                        case ($urandom_range(0, 4))
                            0: hdr.is_udp = 1'b0;
                            1: begin
                                hdr.ip_payload_length = 16'($urandom_range(0, 16'hFFFE));
                                hdr.udp_length = 16'($urandom_range(
                                    hdr.ip_payload_length + 1, 16'hFFFF));
                            end
                            2: hdr.udp_dst_port = 16'($urandom);
                            3: begin
                                hdr.l4_csum_good = 1'b0;
                                hdr.rx_csum_bad  = 1'($urandom_range(0, 1));
                            end
                            default: hdr.msg_type = 4'($urandom_range(2, 15));
                        endcase
                    end
                end
                drive_item(hdr, stamp_verdict(hdr));
            end
        end

        drain();
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ptpts_pkg.sv
hw/rtl/ptpts_front.sv
hw/rtl/ptpts_fifo.sv
hw/rtl/ptpts_back.sv
hw/rtl/ptp_transparent_clock_stamp.sv
sim/tb.sv
